[design/refcounted_id_allocator_defines.svh]
// Assertion macros for the identifier allocator checker.
// Each macro expects clk and rst in scope.
`ifndef REFCOUNTED_ID_ALLOCATOR_DEFINES_SVH
`define REFCOUNTED_ID_ALLOCATOR_DEFINES_SVH

// Same-cycle implication, disabled during reset
`define RCID_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset
`define RCID_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[design/rcid_pkg.sv]
package rcid_pkg;

  // Pool geometry: identifiers are 8 bits, so the pool is capped at 256
  localparam int POOL_ENTRIES = 256;
  localparam int POOL_IDS  = (POOL_ENTRIES < 256) ? POOL_ENTRIES : 256;
  localparam int DEPTH     = 256;
  localparam int ADDR_W    = 8;
  localparam int ID_W      = 8;
  localparam int CNT_W     = 8;

  localparam logic [CNT_W-1:0]  HOLD_MAX  = 8'd255;
  localparam logic [ID_W-1:0]   ID_NONE   = 8'd0;
  localparam logic [ID_W-1:0]   HEAD_INIT = 8'd1;
  localparam logic [ADDR_W-1:0] LAST_ID   = ADDR_W'(POOL_IDS - 1);

  typedef enum logic [1:0] {
    OP_ALLOC = 2'd0,
    OP_DUP   = 2'd1,
    OP_REL   = 2'd2
  } op_t;

  typedef enum logic [1:0] {
    ST_CLEAR = 2'd0,
    ST_IDLE  = 2'd1,
    ST_EXEC  = 2'd2
  } state_t;

  // One access to a single-port memory
  typedef struct packed {
    logic              rd_en;
    logic              wr_en;
    logic [ADDR_W-1:0] addr;
    logic [ID_W-1:0]   wdata;
  } mem_req_t;

  // Reset contents of the free-list link memory
  function automatic logic [ID_W-1:0] link_init(input logic [ADDR_W-1:0] addr);
    logic [ID_W-1:0] nxt;
    nxt = ID_W'(addr) + ID_W'(1);
    return (addr == LAST_ID) ? ID_NONE : nxt;
  endfunction

endpackage

[design/refcounted_id_allocator.sv]
// An accepted request reads the link and holder-count memories, each a single-port RAM
// with a registered read; in the EXEC state its result is loaded into the output register
// once that register is free. A new request is taken only after this read-modify-write.
// A finished result waits in an output register; the next request is taken meanwhile.
// Reset (rst, synchronous, active high) restores the free list 1..255 and clears all
// counts by a clearing pass over all 256 entries after rst falls; s_tready stays low during it.
module refcounted_id_allocator (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // [1:0] opcode, [9:2] id_in, [15:10] zero
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata    // [7:0] id_out, [8] ok, [9] freed, [15:10] zero
);

  rcid_pkg::mem_req_t               link_req;
  rcid_pkg::mem_req_t               cnt_req;
  logic [rcid_pkg::ID_W-1:0]        link_rdata;
  logic [rcid_pkg::CNT_W-1:0]       cnt_rdata;
  logic [rcid_pkg::ID_W-1:0]        id_out;
  logic                             ok;
  logic                             freed;

  rcid_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_tvalid),
    .in_ready   (s_tready),
    .opcode     (s_tdata[1:0]),
    .id_in      (s_tdata[9:2]),
    .out_valid  (m_tvalid),
    .out_ready  (m_tready),
    .id_out     (id_out),
    .ok         (ok),
    .freed      (freed),
    .link_req   (link_req),
    .cnt_req    (cnt_req),
    .link_rdata (link_rdata),
    .cnt_rdata  (cnt_rdata)
  );

  // Free-list links
  rcid_ram #(
    .WIDTH (rcid_pkg::ID_W),
    .DEPTH (rcid_pkg::DEPTH)
  ) u_link_ram (
    .clk   (clk),
    .rd_en (link_req.rd_en),
    .wr_en (link_req.wr_en),
    .addr  (link_req.addr),
    .wdata (link_req.wdata),
    .rdata (link_rdata)
  );

  // Holder counts
  rcid_ram #(
    .WIDTH (rcid_pkg::CNT_W),
    .DEPTH (rcid_pkg::DEPTH)
  ) u_cnt_ram (
    .clk   (clk),
    .rd_en (cnt_req.rd_en),
    .wr_en (cnt_req.wr_en),
    .addr  (cnt_req.addr),
    .wdata (cnt_req.wdata),
    .rdata (cnt_rdata)
  );

  assign m_tdata = {6'd0, freed, ok, id_out};

endmodule

[design/rcid_ram.sv]
module rcid_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     rd_en,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[addr] <= wdata;
    end
  end

  // Registered read, held between reads
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rdata <= mem[addr];
    end
  end

endmodule

[design/rcid_ctrl.sv]
module rcid_ctrl (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [1:0]               opcode,
  input  logic [rcid_pkg::ID_W-1:0] id_in,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic [rcid_pkg::ID_W-1:0] id_out,
  output logic                     ok,
  output logic                     freed,
  output rcid_pkg::mem_req_t       link_req,
  output rcid_pkg::mem_req_t       cnt_req,
  input  logic [rcid_pkg::ID_W-1:0] link_rdata,
  input  logic [rcid_pkg::CNT_W-1:0] cnt_rdata
);

  rcid_pkg::state_t state, state_next;

  logic [1:0]                      op;
  logic [rcid_pkg::ADDR_W-1:0]     addr;
  logic [rcid_pkg::ID_W-1:0]       free_head;
  logic [rcid_pkg::ADDR_W-1:0]     clr_idx;

  logic                            accept;
  logic                            fire;
  logic                            clearing;
  logic                            out_free;
  logic [rcid_pkg::ID_W-1:0]       link_cur;
  logic [rcid_pkg::CNT_W-1:0]      cnt_cur;
  logic                            usable;

  logic                            cnt_we;
  logic [rcid_pkg::CNT_W-1:0]      cnt_wdata;
  logic                            link_we;
  logic                            head_we;
  logic [rcid_pkg::ID_W-1:0]       head_wdata;
  logic [rcid_pkg::ID_W-1:0]       res_id;
  logic                            res_ok;
  logic                            res_freed;
  logic [rcid_pkg::ADDR_W-1:0]     rd_addr;

  assign out_free = !out_valid || out_ready;

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      rcid_pkg::ST_CLEAR: begin
        if (clr_idx == rcid_pkg::ADDR_W'(rcid_pkg::DEPTH - 1)) state_next = rcid_pkg::ST_IDLE;
      end
      rcid_pkg::ST_IDLE: if (in_valid) state_next = rcid_pkg::ST_EXEC;
      rcid_pkg::ST_EXEC: if (out_free) state_next = rcid_pkg::ST_IDLE;
      default:           state_next = rcid_pkg::ST_CLEAR;
    endcase
  end

  // State outputs
  always_comb begin
    in_ready = 1'b0;
    fire     = 1'b0;
    clearing = 1'b0;
    unique case (state)
      rcid_pkg::ST_CLEAR: clearing = 1'b1;
      rcid_pkg::ST_IDLE:  in_ready = 1'b1;
      rcid_pkg::ST_EXEC:  fire     = out_free;
      default:            in_ready = 1'b0;
    endcase
  end

  assign accept = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= rcid_pkg::ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // Walk every entry once after reset
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_idx <= '0;
    end else if (clearing) begin
      clr_idx <= clr_idx + rcid_pkg::ADDR_W'(1);
    end
  end

  // Allocate reads the head entry, the others read the named entry
  assign rd_addr = (opcode == rcid_pkg::OP_ALLOC) ? free_head : id_in;

  // Latch the request
  always_ff @(posedge clk) begin
    if (accept) begin
      op   <= opcode;
      addr <= rd_addr;
    end
  end

  // Memory contents are valid once the clearing pass is done
  assign link_cur = link_rdata;
  assign cnt_cur  = cnt_rdata;
  assign usable   = (addr != '0) && ({1'b0, addr} < 9'(rcid_pkg::POOL_IDS));

  // Modify step
  always_comb begin
    cnt_we     = 1'b0;
    cnt_wdata  = cnt_cur;
    link_we    = 1'b0;
    head_we    = 1'b0;
    head_wdata = link_cur;
    res_id     = rcid_pkg::ID_NONE;
    res_ok     = 1'b0;
    res_freed  = 1'b0;
    unique case (op)
      rcid_pkg::OP_ALLOC: begin
        if (free_head != rcid_pkg::ID_NONE) begin
          cnt_we     = 1'b1;
          cnt_wdata  = rcid_pkg::CNT_W'(1);
          head_we    = 1'b1;
          head_wdata = link_cur;
          res_id     = free_head;
          res_ok     = 1'b1;
        end
      end
      rcid_pkg::OP_DUP: begin
        if (usable && cnt_cur != '0 && cnt_cur < rcid_pkg::HOLD_MAX) begin
          cnt_we    = 1'b1;
          cnt_wdata = cnt_cur + rcid_pkg::CNT_W'(1);
          res_id    = addr;
          res_ok    = 1'b1;
        end
      end
      rcid_pkg::OP_REL: begin
        if (usable && cnt_cur != '0) begin
          cnt_we    = 1'b1;
          cnt_wdata = cnt_cur - rcid_pkg::CNT_W'(1);
          res_ok    = 1'b1;
          if (cnt_cur == rcid_pkg::CNT_W'(1)) begin
            link_we    = 1'b1;
            head_we    = 1'b1;
            head_wdata = addr;
            res_freed  = 1'b1;
          end
        end
      end
      default: begin
        res_ok = 1'b0;
      end
    endcase
  end

  // Memory requests: clear after reset, read at accept, write back when the result is loaded
  always_comb begin
    link_req.rd_en = accept;
    link_req.wr_en = clearing || (fire && link_we);
    link_req.addr  = clearing ? clr_idx : (accept ? rd_addr : addr);
    link_req.wdata = clearing ? rcid_pkg::link_init(clr_idx) : free_head;
    cnt_req.rd_en  = accept;
    cnt_req.wr_en  = clearing || (fire && cnt_we);
    cnt_req.addr   = clearing ? clr_idx : (accept ? rd_addr : addr);
    cnt_req.wdata  = clearing ? '0 : cnt_wdata;
  end

  // Head register
  always_ff @(posedge clk) begin
    if (rst) begin
      free_head <= rcid_pkg::HEAD_INIT;
    end else if (fire && head_we) begin
      free_head <= head_wdata;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fire) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      id_out <= res_id;
      ok     <= res_ok;
      freed  <= res_freed;
    end
  end

endmodule

[design/rcid_checker.sv]
`include "refcounted_id_allocator_defines.svh"

module rcid_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic [15:0] s_tdata,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [15:0] m_tdata
);

  // One request in flight at a time
  `RCID_ASSERT_NEXT(a_one_in_flight, s_tvalid && s_tready, !s_tready, "request overlap")

  // A new result follows a cycle spent executing
  `RCID_ASSERT_NOW(a_result_from_exec, $rose(m_tvalid), $past(!s_tready), "spurious result")

  // A freed identifier comes from a successful release
  `RCID_ASSERT_NOW(a_freed_ok, m_tvalid && m_tdata[9], m_tdata[8] && m_tdata[7:0] == 8'd0, "bad freed result")

  // A returned identifier means the request took effect
  `RCID_ASSERT_NOW(a_id_ok, m_tvalid && m_tdata[7:0] != 8'd0, m_tdata[8] && !m_tdata[9], "id without ok")

endmodule

bind refcounted_id_allocator rcid_checker u_rcid_checker (.*);
